// ===== hdl/gini_pkg.sv =====
// ----------------------------------------------------------------------------
// gini_pkg
// Shared widths, defaults and the status word of the ratio unit.
// ----------------------------------------------------------------------------
package gini_pkg;

    localparam int VALUE_W               = 32;
    localparam int MAX_VALUES_DEFAULT    = 64;
    localparam int FRACTION_BITS_DEFAULT = 16;

    // status of the ratio unit as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } gini_ratio_status_t;

endpackage

// ===== hdl/gini_ratio_unit.sv =====
// ----------------------------------------------------------------------------
// gini_ratio_unit
// Sequential shift-add multiply for 2 * n * total, then restoring long
// division of the pair sum by it, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gini_ratio_unit
    import gini_pkg::*;
#(
    parameter int CNT_W         = 7,
    parameter int TOT_W         = 38,
    parameter int PAIR_W        = 45,
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [CNT_W-1:0]         count,
    input  logic [TOT_W-1:0]         total,
    input  logic [PAIR_W-1:0]        pair_sum,
    output gini_ratio_status_t       status,
    output logic [FRACTION_BITS-1:0] quotient
);

    localparam int DEN_W  = CNT_W + TOT_W + 1;
    localparam int STEP_W = $clog2(FRACTION_BITS);

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_CMP,
        U_DIV
    } unit_state_t;

    unit_state_t              state_reg,  state_next;
    logic                     done_reg,   done_next;
    logic [DEN_W-1:0]         mcand_reg,  mcand_next;
    logic [CNT_W-1:0]         mbits_reg,  mbits_next;
    logic [DEN_W-1:0]         den_reg,    den_next;
    logic [PAIR_W-1:0]        pair_reg,   pair_next;
    logic [DEN_W:0]           rem_reg,    rem_next;
    logic [FRACTION_BITS-1:0] quo_reg,    quo_next;
    logic [STEP_W-1:0]        step_reg,   step_next;

    logic [DEN_W:0] rem_shift;
    logic [DEN_W:0] den_ext;
    logic [DEN_W:0] pair_ext;

    assign den_ext   = {1'b0, den_reg};
    assign pair_ext  = (DEN_W + 1)'(pair_reg);
    assign rem_shift = {rem_reg[DEN_W-1:0], 1'b0};

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        mcand_next = mcand_reg;
        mbits_next = mbits_reg;
        den_next   = den_reg;
        pair_next  = pair_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        case (state_reg)
            U_IDLE: begin
                if (start) begin
                    mcand_next = DEN_W'({total, 1'b0});
                    mbits_next = count;
                    den_next   = '0;
                    pair_next  = pair_sum;
                    state_next = U_MUL;
                end
            end
            U_MUL: begin
                // one multiplier bit a cycle, stop once no bits remain
                if (mbits_reg == '0) begin
                    state_next = U_CMP;
                end else begin
                    if (mbits_reg[0]) begin
                        den_next = den_reg + mcand_reg;
                    end
                    mcand_next = {mcand_reg[DEN_W-2:0], 1'b0};
                    mbits_next = {1'b0, mbits_reg[CNT_W-1:1]};
                end
            end
            U_CMP: begin
                if (pair_ext >= den_ext) begin
                    // saturate: quotient would not fit
                    quo_next   = '1;
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end else begin
                    rem_next   = pair_ext;
                    quo_next   = '0;
                    step_next  = STEP_W'(FRACTION_BITS - 1);
                    state_next = U_DIV;
                end
            end
            U_DIV: begin
                if (rem_shift >= den_ext) begin
                    rem_next = rem_shift - den_ext;
                    quo_next = {quo_reg[FRACTION_BITS-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift;
                    quo_next = {quo_reg[FRACTION_BITS-2:0], 1'b0};
                end
                if (step_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end else begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        mcand_reg <= mcand_next;
        mbits_reg <= mbits_next;
        den_reg   <= den_next;
        pair_reg  <= pair_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        step_reg  <= step_next;
    end

    assign status.busy = (state_reg != U_IDLE);
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// ===== hdl/gini_coefficient_engine.sv =====
// ----------------------------------------------------------------------------
// gini_coefficient_engine
// Gini coefficient of a set of load counts, mean absolute difference form.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one unsigned count per word; s_last marks the final
//   word of a set. Each stored count is compared with every count already in
//   the value memory; the first word of a set has nothing to walk. A single
//   memory read port walks the store. A word that arrives with the store full
//   is dropped and flagged. On a last word the ratio unit forms 2 * n * total
//   by shift-add over the bits of n, the number of counts stored, and then
//   divides, one fraction bit per cycle.
//   The m_ channel carries one result word per set: the Q0.FRACTION_BITS
//   fraction, the count, a zero-total flag and a capacity flag.
//   The result sits in an output register; the next set may start streaming
//   in while the receiver stalls, and the engine only waits once a second
//   result is ready. Reset empties the store and clears every accumulator;
//   the memory itself needs no clearing, only entries of the current set are
//   ever read.
// ----------------------------------------------------------------------------
module gini_coefficient_engine
    import gini_pkg::*;
#(
    parameter int MAX_VALUES    = MAX_VALUES_DEFAULT,
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
    localparam int CNT_W        = $clog2(MAX_VALUES + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [VALUE_W-1:0]       s_value,
    input  logic                     s_last,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [FRACTION_BITS-1:0] m_gini_fraction,
    output logic [CNT_W-1:0]         m_value_count,
    output logic                     m_zero_total,
    output logic                     m_capacity_exceeded
);

    localparam int IDX_W  = $clog2(MAX_VALUES);
    localparam int TOT_W  = VALUE_W + IDX_W;
    localparam int PAIR_W = VALUE_W + 2 * IDX_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_STORE,
        ST_RATIO,
        ST_HOLD
    } state_t;

    // sequencer state and accumulators
    state_t              state_reg,   state_next;
    logic [VALUE_W-1:0]  cur_reg,     cur_next;
    logic                last_reg,    last_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [TOT_W-1:0]    total_reg,   total_next;
    logic [PAIR_W-1:0]   pair_reg,    pair_next;
    logic                drop_reg,    drop_next;
    logic [IDX_W-1:0]    rd_idx_reg,  rd_idx_next;

    // read pipeline: memory output, then absolute difference
    logic                rd_vld_reg;
    logic                diff_vld_reg;
    logic [VALUE_W-1:0]  diff_reg;
    logic [VALUE_W-1:0]  mem_q_reg;

    // output register
    logic                     m_valid_reg,  m_valid_next;
    logic [FRACTION_BITS-1:0] m_frac_reg,   m_frac_next;
    logic [CNT_W-1:0]         m_count_reg,  m_count_next;
    logic                     m_zero_reg,   m_zero_next;
    logic                     m_cap_reg,    m_cap_next;

    logic                mem_rd_en;
    logic                mem_wr_en;
    logic                ratio_start;
    gini_ratio_status_t  ratio_stat;
    logic [FRACTION_BITS-1:0] ratio_quo;

    logic                s_fire;
    logic                has_room;
    logic                walk_end;
    logic                out_free;
    logic [CNT_W-1:0]    count_m1;
    logic [VALUE_W-1:0]  abs_diff;

    logic [VALUE_W-1:0]  value_mem [MAX_VALUES];

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign has_room = (count_reg < CNT_W'(MAX_VALUES));
    assign count_m1 = count_reg - CNT_W'(1);
    assign walk_end = (CNT_W'(rd_idx_reg) == count_m1);
    assign out_free = !m_valid_reg || m_ready;
    assign abs_diff = (cur_reg >= mem_q_reg) ? (cur_reg - mem_q_reg) : (mem_q_reg - cur_reg);

    assign mem_rd_en = (state_reg == ST_WALK);
    assign mem_wr_en = (state_reg == ST_STORE);

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        pair_next    = pair_reg;
        drop_next    = drop_reg;
        rd_idx_next  = rd_idx_reg;
        ratio_start  = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        m_frac_next  = m_frac_reg;
        m_count_next = m_count_reg;
        m_zero_next  = m_zero_reg;
        m_cap_next   = m_cap_reg;

        // fold each difference in twice: both ordered pairs
        if (diff_vld_reg) begin
            pair_next = pair_reg + {(PAIR_W - VALUE_W - 1)'(0), diff_reg, 1'b0};
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    cur_next  = s_value;
                    last_next = s_last;
                    if (!has_room) begin
                        // store full: drop the word, keep the flag
                        drop_next = 1'b1;
                        if (s_last) begin
                            ratio_start = 1'b1;
                            state_next  = ST_RATIO;
                        end
                    end else if (count_reg == '0) begin
                        state_next = ST_STORE;
                    end else begin
                        rd_idx_next = '0;
                        state_next  = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                // one read a cycle over the stored entries
                rd_idx_next = rd_idx_reg + IDX_W'(1);
                if (walk_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the read pipeline to empty into the pair sum
                if (!rd_vld_reg && !diff_vld_reg) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                count_next = count_reg + CNT_W'(1);
                total_next = total_reg + TOT_W'(cur_reg);
                if (last_reg) begin
                    ratio_start = 1'b1;
                    state_next  = ST_RATIO;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_RATIO: begin
                if (ratio_stat.done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                // hand over the result once the output register frees, then clear
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_frac_next  = (total_reg == '0) ? '0 : ratio_quo;
                    m_count_next = count_reg;
                    m_zero_next  = (total_reg == '0);
                    m_cap_next   = drop_reg;
                    count_next   = '0;
                    total_next   = '0;
                    pair_next    = '0;
                    drop_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            total_reg    <= '0;
            pair_reg     <= '0;
            drop_reg     <= 1'b0;
            rd_vld_reg   <= 1'b0;
            diff_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            pair_reg     <= pair_next;
            drop_reg     <= drop_next;
            rd_vld_reg   <= mem_rd_en;
            diff_vld_reg <= rd_vld_reg;
            m_valid_reg  <= m_valid_next;
        end
        cur_reg     <= cur_next;
        last_reg    <= last_next;
        rd_idx_reg  <= rd_idx_next;
        diff_reg    <= abs_diff;
        m_frac_reg  <= m_frac_next;
        m_count_reg <= m_count_next;
        m_zero_reg  <= m_zero_next;
        m_cap_reg   <= m_cap_next;
    end

    // value store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            value_mem[count_reg[IDX_W-1:0]] <= cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            mem_q_reg <= value_mem[rd_idx_reg];
        end
    end

    // hand over the count and total as they stand once the closing word is in
    gini_ratio_unit #(
        .CNT_W         (CNT_W),
        .TOT_W         (TOT_W),
        .PAIR_W        (PAIR_W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ratio (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ratio_start),
        .count    (count_next),
        .total    (total_next),
        .pair_sum (pair_reg),
        .status   (ratio_stat),
        .quotient (ratio_quo)
    );

    assign m_valid             = m_valid_reg;
    assign m_gini_fraction     = m_frac_reg;
    assign m_value_count       = m_count_reg;
    assign m_zero_total        = m_zero_reg;
    assign m_capacity_exceeded = m_cap_reg;

    // the walk reads and the store writes never share a cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_rd_en && mem_wr_en))
        else $error("value store read and write in the same cycle");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_VALUES))
        else $error("stored count beyond capacity");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ratio_start |-> !ratio_stat.busy)
        else $error("ratio unit started while busy");

    a_done_in_ratio: assert property (@(posedge aclk) disable iff (!aresetn)
        ratio_stat.done |-> (state_reg == ST_RATIO))
        else $error("ratio result outside the ratio wait");

    a_pipe_empty_store: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (!rd_vld_reg && !diff_vld_reg))
        else $error("store written with differences still in flight");

endmodule

// ===== tb/gini_coefficient_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gini_coefficient_engine_tb
// Self-checking bench for the Gini coefficient engine.
// ----------------------------------------------------------------------------
// Streams sets of load counts into the s_ channel and checks every result
// word on the m_ channel against an in-bench model of the engine or a typed
// table entry. A short table of directed sets (extremes, zero totals, a full
// store) comes first, then random sets of mixed size and value spread under
// three idling regimes and one long receiver hold-off that backs the engine up.
// ----------------------------------------------------------------------------
module gini_coefficient_engine_tb
    import gini_pkg::*;
();

    localparam int CAPACITY         = MAX_VALUES_DEFAULT;
    localparam int FRAC_W           = FRACTION_BITS_DEFAULT;
    localparam int CNT_W            = $clog2(CAPACITY + 1);
    localparam int HALF_PERIOD      = 2;
    localparam int ITEMS_PER_PHASE  = 495;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int DRAIN_LIMIT      = 50000;
    localparam int SETTLE_CYCLES    = 200;
    localparam int DIRECTED_ROWS    = 25;

    // one result word as the engine presents it
    typedef struct packed {
        logic [FRAC_W-1:0] fraction;
        logic [CNT_W-1:0]  count;
        logic              zero_total;
        logic              capacity_exceeded;
    } gini_result_t;

    // one row of the directed table; reps repeats the word, last on the final copy only
    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               last;
        int                 reps;
        bit                 typed;
        gini_result_t       want;
    } stim_row_t;

    typedef enum int {
        SET_WIDE,
        SET_NARROW,
        SET_ZERO,
        SET_EXTREME
    } set_style_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [VALUE_W-1:0] s_value;
    logic               s_last;
    logic               m_valid;
    logic               m_ready;
    logic [FRAC_W-1:0]  m_gini_fraction;
    logic [CNT_W-1:0]   m_value_count;
    logic               m_zero_total;
    logic               m_capacity_exceeded;

    // travel with the payload: a typed expectation replaces the model's one
    bit                 word_is_typed;
    gini_result_t       typed_result;

    // model state of the current set
    logic [VALUE_W-1:0] held_values [CAPACITY];
    int unsigned        held_n;
    logic [63:0]        held_total;
    logic [63:0]        pair_sum;
    bit                 dropped;

    gini_result_t       expected_results [$];
    int                 mismatch_count;

    int                 send_idle_pct;
    int                 recv_idle_pct;
    bit                 hold_request;
    int                 hold_left;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // single zero: zero total
        '{32'h0000_0000, 1'b1, 1,  1'b1, '{16'h0000, 7'd1,  1'b1, 1'b0}},
        // single full-scale value: no spread
        '{32'hFFFF_FFFF, 1'b1, 1,  1'b1, '{16'h0000, 7'd1,  1'b0, 1'b0}},
        '{32'h0000_0000, 1'b0, 1,  1'b0, '0},
        '{32'hFFFF_FFFF, 1'b1, 1,  1'b1, '{16'h8000, 7'd2,  1'b0, 1'b0}},
        '{32'h0000_0001, 1'b0, 1,  1'b0, '0},
        '{32'h0000_0003, 1'b1, 1,  1'b1, '{16'h4000, 7'd2,  1'b0, 1'b0}},
        // several zeros: zero total
        '{32'h0000_0000, 1'b0, 2,  1'b0, '0},
        '{32'h0000_0000, 1'b1, 1,  1'b1, '{16'h0000, 7'd3,  1'b1, 1'b0}},
        '{32'd1000,      1'b0, 2,  1'b0, '0},
        '{32'd1000,      1'b1, 1,  1'b1, '{16'h0000, 7'd3,  1'b0, 1'b0}},
        // one holder of all load among eight: 7/8
        '{32'h0000_0000, 1'b0, 7,  1'b0, '0},
        '{32'hFFFF_FFFF, 1'b1, 1,  1'b1, '{16'hE000, 7'd8,  1'b0, 1'b0}},
        '{32'd5,         1'b0, 1,  1'b0, '0},
        '{32'd17,        1'b0, 1,  1'b0, '0},
        '{32'd100,       1'b1, 1,  1'b0, '0},
        '{32'h8000_0000, 1'b0, 1,  1'b0, '0},
        '{32'h7FFF_FFFF, 1'b0, 1,  1'b0, '0},
        '{32'h5555_5555, 1'b0, 1,  1'b0, '0},
        '{32'hAAAA_AAAA, 1'b1, 1,  1'b0, '0},
        // store full: the last word is dropped yet still closes the set
        '{32'd7,         1'b0, 64, 1'b0, '0},
        '{32'd9,         1'b1, 1,  1'b1, '{16'h0000, 7'd64, 1'b0, 1'b1}},
        // store full with every value zero
        '{32'h0000_0000, 1'b0, 65, 1'b0, '0},
        '{32'h0000_0000, 1'b1, 1,  1'b1, '{16'h0000, 7'd64, 1'b1, 1'b1}},
        // flag and sums must have cleared after the full set
        '{32'd2,         1'b0, 1,  1'b0, '0},
        '{32'd6,         1'b1, 1,  1'b1, '{16'h4000, 7'd2,  1'b0, 1'b0}}
    };

    gini_coefficient_engine dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_value             (s_value),
        .s_last              (s_last),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_gini_fraction     (m_gini_fraction),
        .m_value_count       (m_value_count),
        .m_zero_total        (m_zero_total),
        .m_capacity_exceeded (m_capacity_exceeded)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Absorb one accepted count into the model; on a last word form the result
    // and clear the set. Returns 1 when a result word is due.
    function automatic bit absorb_count(input logic [VALUE_W-1:0] v, input logic lst,
                                        output gini_result_t res);
        logic [63:0]       diff;
        logic [63:0]       den;
        logic [63:0]       rem;
        logic [FRAC_W-1:0] quo;
        res = '0;
        if (held_n < CAPACITY) begin
            for (int i = 0; i < held_n; i++) begin
                diff = (v >= held_values[i]) ? 64'(v - held_values[i])
                                             : 64'(held_values[i] - v);
                pair_sum += diff << 1;
            end
            held_values[held_n] = v;
            held_n++;
            held_total += 64'(v);
        end else begin
            dropped = 1'b1;
        end
        if (!lst) begin
            return 1'b0;
        end
        quo = '0;
        if (held_total != 0) begin
            den = (held_total * 64'(held_n)) << 1;
            if (pair_sum >= den) begin
                quo = '1;
            end else begin
                // restoring long division, one fraction bit per step
                rem = pair_sum;
                for (int k = 0; k < FRAC_W; k++) begin
                    rem = rem << 1;
                    quo = quo << 1;
                    if (rem >= den) begin
                        rem -= den;
                        quo[0] = 1'b1;
                    end
                end
            end
        end
        res.fraction          = quo;
        res.count             = CNT_W'(held_n);
        res.zero_total        = (held_total == 0);
        res.capacity_exceeded = dropped;
        held_n     = 0;
        held_total = '0;
        pair_sum   = '0;
        dropped    = 1'b0;
        return 1'b1;
    endfunction

    // Sample both channels at the rising edge: predict on accepted input words,
    // check accepted result words against the oldest expectation.
    always @(posedge aclk) begin
        gini_result_t predicted;
        gini_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (absorb_count(s_value, s_last, predicted)) begin
                    expected_results.insert(expected_results.size(),
                                            word_is_typed ? typed_result : predicted);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (m_gini_fraction !== want.fraction) begin
                        report_mismatch($sformatf("gini_fraction %h, expected %h",
                                                  m_gini_fraction, want.fraction));
                    end
                    if (m_value_count !== want.count) begin
                        report_mismatch($sformatf("value_count %0d, expected %0d",
                                                  m_value_count, want.count));
                    end
                    if (m_zero_total !== want.zero_total) begin
                        report_mismatch($sformatf("zero_total %b, expected %b",
                                                  m_zero_total, want.zero_total));
                    end
                    if (m_capacity_exceeded !== want.capacity_exceeded) begin
                        report_mismatch($sformatf("capacity_exceeded %b, expected %b",
                                                  m_capacity_exceeded,
                                                  want.capacity_exceeded));
                    end
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off once requested.
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left    = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offer one word from a falling edge; return at the falling edge after it is taken.
    task automatic send_word(input logic [VALUE_W-1:0] v, input logic lst,
                             input bit typed, input gini_result_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_value       <= v;
        s_last        <= lst;
        word_is_typed <= typed;
        typed_result  <= want;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_count(input set_style_t style);
        case (style)
            SET_WIDE:   return $urandom;
            SET_NARROW: return $urandom_range(0, 15);
            SET_ZERO:   return '0;
            default: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
                    default: return 32'd1 << $urandom_range(0, 31);
                endcase
            end
        endcase
    endfunction

    // mostly short sets; a few fill the store or overrun it
    function automatic int pick_set_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
            return $urandom_range(1, 12);
        end else if (roll < 95) begin
            return $urandom_range(13, CAPACITY);
        end
        return $urandom_range(CAPACITY + 1, CAPACITY + 8);
    endfunction

    initial begin
        set_style_t style;
        int         size;
        int         sent;
        int         waited;
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_value        = '0;
        s_last         = 1'b0;
        m_ready        = 1'b0;
        word_is_typed  = 1'b0;
        typed_result   = '0;
        held_n         = 0;
        held_total     = '0;
        pair_sum       = '0;
        dropped        = 1'b0;
        mismatch_count = 0;
        send_idle_pct  = 20;
        recv_idle_pct  = 73;
        hold_request   = 1'b0;
        hold_left      = 0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // walk the directed table
        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                if (k == directed_rows[r].reps - 1) begin
                    send_word(directed_rows[r].value, directed_rows[r].last,
                              directed_rows[r].typed, directed_rows[r].want);
                end else begin
                    send_word(directed_rows[r].value, 1'b0, 1'b0, '0);
                end
            end
        end

        // random sets under three idling regimes
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 20; recv_idle_pct = 73; end
                1: begin send_idle_pct = 73; recv_idle_pct = 20; end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_request  = 1'b1;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                style = set_style_t'($urandom_range(0, 9) < 6 ?
                                     $urandom_range(0, 1) : $urandom_range(0, 3));
                size  = pick_set_size();
                for (int k = 0; k < size; k++) begin
                    send_word(pick_count(style), k == size - 1, 1'b0, '0);
                end
                sent += size;
            end
        end
        s_valid <= 1'b0;

        // drain outstanding results, then let any stray word show up
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected result words never arrived",
                                      expected_results.size()));
        end

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #(64'd8_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule
